// ===== src/salt_pkg.sv =====
// Shared types and constants for the stack assembly line tokenizer.
`default_nettype none

package salt_pkg;

  localparam int CHAR_W    = 8;
  localparam int OPCODE_W  = 4;
  localparam int OPERAND_W = 32;
  localparam int TOKEN_MAX = 6;
  localparam int TLEN_W    = 3;

  typedef logic [OPCODE_W-1:0] opcode_t;

  localparam opcode_t OP_PUSH   = 4'd0;
  localparam opcode_t OP_DROP   = 4'd1;
  localparam opcode_t OP_DUP    = 4'd2;
  localparam opcode_t OP_SWAP   = 4'd3;
  localparam opcode_t OP_OVER   = 4'd4;
  localparam opcode_t OP_NOT    = 4'd5;
  localparam opcode_t OP_EQ     = 4'd6;
  localparam opcode_t OP_LT     = 4'd7;
  localparam opcode_t OP_JUMP   = 4'd8;
  localparam opcode_t OP_JUMPIF = 4'd9;
  localparam opcode_t OP_ADD    = 4'd10;
  localparam opcode_t OP_PRINT  = 4'd11;
  localparam opcode_t OP_END    = 4'd12;
  localparam opcode_t OP_NONE   = 4'd15;

  localparam logic [CHAR_W-1:0] CH_NUL      = 8'd0;
  localparam logic [CHAR_W-1:0] CH_TAB      = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NL       = 8'd10;
  localparam logic [CHAR_W-1:0] CH_SPACE    = 8'd32;
  localparam logic [CHAR_W-1:0] CH_HASH     = 8'd35;
  localparam logic [CHAR_W-1:0] CH_ZERO     = 8'd48;
  localparam logic [CHAR_W-1:0] CH_NINE     = 8'd57;
  localparam logic [CHAR_W-1:0] CH_UPPER_A  = 8'd65;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z  = 8'd90;
  localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'd32;

  typedef enum logic [2:0] {
    PH_LINE,
    PH_TOKEN,
    PH_GAP,
    PH_DIGITS,
    PH_IGNORE
  } phase_t;

  // Element 0 holds the first character of the token.
  typedef logic [TOKEN_MAX-1:0][CHAR_W-1:0] token_t;

  typedef struct packed {
    phase_t            phase;
    token_t            chars;
    logic [TLEN_W-1:0] len;
    logic              too_long;
    opcode_t           pending;
  } state_t;

  typedef struct packed {
    opcode_t                opcode;
    logic [OPERAND_W-1:0]   operand;
    logic                   overflow;
    logic                   last_of_run;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } step_out_t;

  localparam state_t STATE_RESET = '{
    phase:    PH_LINE,
    chars:    '0,
    len:      '0,
    too_long: 1'b0,
    pending:  OP_NONE
  };

endpackage

`default_nettype wire

// ===== src/salt_in_if.sv =====
// Character input channel: one source byte and its end flags per word.
`default_nettype none

interface salt_in_if;
  logic                         valid;
  logic                         ready;
  logic [salt_pkg::CHAR_W-1:0]  char_code;
  logic                         end_of_text;
  logic                         byte_present;

  modport source (output valid, char_code, end_of_text, byte_present, input ready);
  modport sink   (input valid, char_code, end_of_text, byte_present, output ready);
endinterface

`default_nettype wire

// ===== src/salt_out_if.sv =====
// Instruction output channel: one decoded instruction per word.
`default_nettype none

interface salt_out_if;
  logic                           valid;
  logic                           ready;
  logic [salt_pkg::OPCODE_W-1:0]  opcode;
  logic [salt_pkg::OPERAND_W-1:0] operand;
  logic                           overflow;
  logic                           last_of_run;

  modport source (output valid, opcode, operand, overflow, last_of_run, input ready);
  modport sink   (input valid, opcode, operand, overflow, last_of_run, output ready);
endinterface

`default_nettype wire

// ===== src/salt_step.sv =====
// Combinational next-state and instruction logic for one input word.
`default_nettype none

module salt_step #(
  parameter int OPERAND_BITS = 32
) (
  input  salt_pkg::state_t                cur,
  input  logic [OPERAND_BITS-1:0]         acc,
  input  logic                            acc_ovf,
  input  logic [salt_pkg::CHAR_W-1:0]     char_code,
  input  logic                            end_of_text,
  input  logic                            byte_present,
  output salt_pkg::state_t                nxt,
  output logic [OPERAND_BITS-1:0]         acc_next,
  output logic                            acc_ovf_next,
  output salt_pkg::step_out_t             res
);
  import salt_pkg::*;

  localparam int MN_COUNT = 12;
  localparam int EXT_W = (OPERAND_BITS > OPERAND_W) ? OPERAND_BITS : OPERAND_W;
  localparam logic [CHAR_W-1:0] NB = 8'd0;

  // Mnemonic spellings, zero padded; the table position is the opcode.
  localparam token_t MN_TEXT [MN_COUNT] = '{
    {NB, NB, "h", "s", "u", "p"},
    {NB, NB, "p", "o", "r", "d"},
    {NB, NB, NB, "p", "u", "d"},
    {NB, NB, "p", "a", "w", "s"},
    {NB, NB, "r", "e", "v", "o"},
    {NB, NB, NB, "t", "o", "n"},
    {NB, NB, NB, NB, "q", "e"},
    {NB, NB, NB, NB, "t", "l"},
    {NB, NB, "p", "m", "u", "j"},
    {"f", "i", "p", "m", "u", "j"},
    {NB, NB, NB, "d", "d", "a"},
    {NB, "t", "n", "i", "r", "p"}
  };

  // Token characters past the length are always zero, so a full compare also
  // checks the length.
  function automatic opcode_t match_token(token_t t, logic too_long);
    opcode_t op;
    op = OP_NONE;
    for (int i = 0; i < MN_COUNT; i++) begin
      if (!too_long && t == MN_TEXT[i]) op = opcode_t'(i);
    end
    return op;
  endfunction

  function automatic logic takes_operand(opcode_t op);
    return (op == OP_PUSH) || (op == OP_JUMP) || (op == OP_JUMPIF);
  endfunction

  function automatic result_t make_result(opcode_t op, logic [OPERAND_W-1:0] val,
                                          logic ovf);
    result_t r;
    r.opcode      = op;
    r.operand     = val;
    r.overflow    = ovf;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  logic [CHAR_W-1:0]       c;
  logic                    is_blank;
  logic                    is_nl;
  logic                    is_nul;
  logic                    is_digit;
  phase_t                  line_end_phase;
  opcode_t                 cur_op;
  opcode_t                 mid_op;
  logic [OPERAND_BITS+3:0] acc_x10;
  logic                    acc_carry;
  logic [EXT_W-1:0]        cur_wide;
  logic [EXT_W-1:0]        mid_wide;
  state_t                  mid;
  logic [OPERAND_BITS-1:0] mid_acc;
  logic                    mid_ovf;
  logic                    byte_v;
  result_t                 byte_r;
  logic                    flush_v;
  result_t                 flush_r;
  result_t                 end_r;

  always_comb begin
    c = char_code;
    if (char_code inside {[CH_UPPER_A:CH_UPPER_Z]}) c = char_code + CASE_OFFSET;
  end

  assign is_blank       = (c == CH_SPACE) || (c == CH_TAB);
  assign is_nl          = (c == CH_NL);
  assign is_nul         = (c == CH_NUL);
  assign is_digit       = (c >= CH_ZERO) && (c <= CH_NINE);
  assign line_end_phase = is_nl ? PH_LINE : PH_IGNORE;

  assign cur_op = match_token(cur.chars, cur.too_long);
  assign mid_op = match_token(mid.chars, mid.too_long);

  // Times ten plus the digit, kept four bits wider to see the wrap.
  assign acc_x10 = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0}
                 + {{OPERAND_BITS{1'b0}}, c[3:0]};
  assign acc_carry = |acc_x10[OPERAND_BITS+3:OPERAND_BITS];

  assign cur_wide = EXT_W'(acc);
  assign mid_wide = EXT_W'(mid_acc);

  // Byte stage: effect of the character itself.
  always_comb begin
    mid     = cur;
    mid_acc = acc;
    mid_ovf = acc_ovf;
    byte_v  = 1'b0;
    byte_r  = make_result(OP_NONE, '0, 1'b0);
    if (byte_present) begin
      case (cur.phase)
        PH_TOKEN: begin
          if (is_blank || is_nl || is_nul) begin
            if (takes_operand(cur_op)) begin
              mid.pending = cur_op;
              mid_acc     = '0;
              mid_ovf     = 1'b0;
              if (is_blank) begin
                mid.phase = PH_GAP;
              end else begin
                byte_v    = 1'b1;
                byte_r    = make_result(cur_op, '0, 1'b0);
                mid.phase = line_end_phase;
              end
            end else begin
              if (cur_op != OP_NONE) begin
                byte_v = 1'b1;
                byte_r = make_result(cur_op, '0, 1'b0);
              end
              mid.phase = is_blank ? PH_IGNORE : line_end_phase;
            end
          end else if (cur.len < TLEN_W'(TOKEN_MAX)) begin
            mid.chars[cur.len] = c;
            mid.len            = cur.len + TLEN_W'(1);
          end else begin
            mid.too_long = 1'b1;
          end
        end
        PH_GAP, PH_DIGITS: begin
          if (is_digit) begin
            mid_acc   = acc_x10[OPERAND_BITS-1:0];
            mid_ovf   = acc_ovf | acc_carry;
            mid.phase = PH_DIGITS;
          end else if (!(cur.phase == PH_GAP && is_blank)) begin
            byte_v    = 1'b1;
            byte_r    = make_result(cur.pending, cur_wide[OPERAND_W-1:0], acc_ovf);
            mid.phase = line_end_phase;
          end
        end
        PH_IGNORE: begin
          if (is_nl) mid.phase = PH_LINE;
        end
        default: begin
          if (is_blank || is_nl) begin
            mid.phase = PH_LINE;
          end else if (c == CH_HASH || is_nul) begin
            mid.phase = PH_IGNORE;
          end else begin
            mid.chars    = '0;
            mid.chars[0] = c;
            mid.len      = TLEN_W'(1);
            mid.too_long = 1'b0;
            mid.phase    = PH_TOKEN;
          end
        end
      endcase
    end
  end

  // Next state: end of text returns everything to the reset values.
  always_comb begin
    if (end_of_text) begin
      nxt          = STATE_RESET;
      acc_next     = '0;
      acc_ovf_next = 1'b0;
    end else begin
      nxt          = mid;
      acc_next     = mid_acc;
      acc_ovf_next = mid_ovf;
    end
  end

  // Results: the byte's instruction; at end of text, that or the flushed one, then the end marker.
  always_comb begin
    flush_v = 1'b0;
    flush_r = make_result(OP_NONE, '0, 1'b0);
    end_r   = make_result(OP_END, '0, 1'b0);
    end_r.last_of_run = 1'b1;
    if (mid.phase == PH_TOKEN) begin
      flush_v = (mid_op != OP_NONE);
      flush_r = make_result(mid_op, '0, 1'b0);
    end else if (mid.phase == PH_GAP || mid.phase == PH_DIGITS) begin
      flush_v = 1'b1;
      flush_r = make_result(mid.pending, mid_wide[OPERAND_W-1:0], mid_ovf);
    end

    res.first  = byte_r;
    res.second = end_r;
    if (!end_of_text) begin
      res.count             = {1'b0, byte_v};
      res.first.last_of_run = 1'b1;
    end else if (byte_v) begin
      res.count = 2'd2;
    end else if (flush_v) begin
      res.count = 2'd2;
      res.first = flush_r;
    end else begin
      res.count = 2'd1;
      res.first = end_r;
    end
  end

endmodule

`default_nettype wire

// ===== src/salt_outbuf.sv =====
// Two-entry output buffer that drains the instructions of one word in order.
`default_nettype none

module salt_outbuf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  salt_pkg::step_out_t  res,
  output logic                 room,
  salt_out_if.source           tokens
);
  import salt_pkg::*;

  result_t slot0;
  result_t slot1;
  logic    v0;
  logic    v1;
  logic    pop;
  logic    fill;

  assign pop  = v0 && tokens.ready;
  assign room = !v1 && (!v0 || pop);
  assign fill = load && (res.count != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else if (fill) begin
      v0 <= 1'b1;
      v1 <= (res.count == 2'd2);
    end else if (pop) begin
      v0 <= v1;
      v1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fill) begin
      slot0 <= res.first;
      slot1 <= res.second;
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

  assign tokens.valid       = v0;
  assign tokens.opcode      = slot0.opcode;
  assign tokens.operand     = slot0.operand;
  assign tokens.overflow    = slot0.overflow;
  assign tokens.last_of_run = slot0.last_of_run;

  a_second_needs_first: assert property (@(posedge clk) disable iff (rst)
    v1 |-> v0)
    else $error("second output entry held without a first");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (v0 && slot0.opcode == OP_END) |-> slot0.last_of_run)
    else $error("end marker not flagged as last of its word");

endmodule

`default_nettype wire

// ===== src/stack_asm_line_tokenizer.sv =====
// Top level of the stack assembly line tokenizer.
// An accepted word passes the input register, then the output buffer, before it is shown.
// Throughput: one word per cycle while each word yields at most one instruction and the
// output takes every instruction; a word that yields two (an instruction and the end marker)
// holds the input until the first has left; the two-entry output buffer and the input register set this.
// Reset (rst, synchronous) returns the tokenizer to the start of a line.
`default_nettype none

module stack_asm_line_tokenizer #(
  parameter int OPERAND_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  salt_in_if.sink     text,
  salt_out_if.source  tokens
);
  import salt_pkg::*;

  // Input register: holds one word until its instructions fit the buffer.
  logic                s1_v;
  logic [CHAR_W-1:0]   s1_char;
  logic                s1_eot;
  logic                s1_present;

  // Tokenizer state.
  state_t                  st;
  logic [OPERAND_BITS-1:0] acc;
  logic                    acc_ovf;

  state_t                  st_next;
  logic [OPERAND_BITS-1:0] acc_next;
  logic                    acc_ovf_next;
  step_out_t               step_res;
  logic                    room;
  logic                    go;
  logic                    advance;

  // A word that yields nothing never waits; otherwise the buffer must have
  // space for both possible instructions.
  assign go      = (step_res.count == 2'd0) || room;
  assign advance = s1_v && go;

  assign text.ready = !s1_v || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (text.ready) begin
      s1_v <= text.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text.ready && text.valid) begin
      s1_char    <= text.char_code;
      s1_eot     <= text.end_of_text;
      s1_present <= text.byte_present;
    end
  end

  // The state moves only when the registered word is consumed.
  always_ff @(posedge clk) begin
    if (rst) begin
      st      <= STATE_RESET;
      acc     <= '0;
      acc_ovf <= 1'b0;
    end else if (advance) begin
      st      <= st_next;
      acc     <= acc_next;
      acc_ovf <= acc_ovf_next;
    end
  end

  salt_step #(
    .OPERAND_BITS(OPERAND_BITS)
  ) u_step (
    .cur          (st),
    .acc          (acc),
    .acc_ovf      (acc_ovf),
    .char_code    (s1_char),
    .end_of_text  (s1_eot),
    .byte_present (s1_present),
    .nxt          (st_next),
    .acc_next     (acc_next),
    .acc_ovf_next (acc_ovf_next),
    .res          (step_res)
  );

  salt_outbuf u_outbuf (
    .clk    (clk),
    .rst    (rst),
    .load   (advance),
    .res    (step_res),
    .room   (room),
    .tokens (tokens)
  );

  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_eot) |=> (st.phase == PH_LINE && st.pending == OP_NONE))
    else $error("state not back at line start after end of text");

  a_operand_pending: assert property (@(posedge clk) disable iff (rst)
    (st.phase == PH_GAP || st.phase == PH_DIGITS) |->
      (st.pending == OP_PUSH || st.pending == OP_JUMP || st.pending == OP_JUMPIF))
    else $error("operand phase without an operand mnemonic");

  a_token_length: assert property (@(posedge clk) disable iff (rst)
    (st.phase == PH_TOKEN) |-> (st.len != '0 && st.len <= TLEN_W'(TOKEN_MAX)))
    else $error("token length out of range");

endmodule

`default_nettype wire
